// File: hdl/trm_pkg.sv
// Shared types and constants of the register machine execute core.
package trm_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OPC_W     = 4;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned BR_W      = 6;
  localparam int unsigned LINE_W    = 5;
  localparam int unsigned CNT_W     = $clog2(DATA_W);

  typedef enum logic [OPC_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LET   = 4'd4,
    OP_BGE   = 4'd5,
    OP_PRINT = 4'd6,
    OP_END   = 4'd7
  } trm_op_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_CMP,
    ALU_MUL,
    ALU_DIV
  } trm_alu_mode_e;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic [REG_IDX_W-1:0]     first_reg;
    logic [REG_IDX_W-1:0]     second_reg;
    logic [REG_IDX_W-1:0]     third_reg;
    logic signed [DATA_W-1:0] immediate_value;
    logic [BR_W-1:0]          branch_line;
  } trm_instr_t;

  typedef struct packed {
    logic [LINE_W-1:0]        next_line;
    logic                     print_valid;
    logic [REG_IDX_W-1:0]     print_reg;
    logic signed [DATA_W-1:0] print_value;
    logic                     halted;
    logic                     unknown_op;
    logic                     divide_by_zero;
  } trm_result_t;

  // Control from the sequencer to the serial datapath
  typedef struct packed {
    logic          load;
    logic          step;
    logic          fix;
    logic          last;
    trm_alu_mode_e mode;
  } trm_alu_ctl_t;

endpackage

// File: hdl/trm_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface trm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/trm_ram.sv
// Generic RAM with one write port and two registered read ports.
module trm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hdl/trm_alu.sv
// Serial datapath: bit-serial add, subtract and compare, shift-add multiply,
// restoring divide one quotient bit per cycle.
module trm_alu
  import trm_pkg::*;
(
  input  logic              clk_i,
  input  trm_alu_ctl_t      ctl_i,
  input  logic [DATA_W-1:0] opa_i,
  input  logic [DATA_W-1:0] opb_i,
  output logic [DATA_W-1:0] result_o,
  output logic              ge_o
);

  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] acc_q;
  logic              carry_q;
  logic              ge_q;
  logic              neg_q;

  logic              b_bit;
  logic              sum_bit;
  logic              carry_out;
  logic [DATA_W-1:0] mul_sum;
  logic [DATA_W-1:0] rem_shift;
  logic              rem_fits;
  logic [DATA_W-1:0] rem_sub;
  logic [DATA_W-1:0] abs_a;
  logic [DATA_W-1:0] abs_b;

  // Magnitudes of the operands for the divider
  assign abs_a = opa_i[DATA_W-1] ? (DATA_W'(0) - opa_i) : opa_i;
  assign abs_b = opb_i[DATA_W-1] ? (DATA_W'(0) - opb_i) : opb_i;

  // One bit of the serial adder, subtract by inverting b with carry in set
  assign b_bit     = b_q[0] ^ (ctl_i.mode == ALU_SUB);
  assign sum_bit   = a_q[0] ^ b_bit ^ carry_q;
  assign carry_out = (a_q[0] & b_bit) | (a_q[0] & carry_q) | (b_bit & carry_q);

  // One partial product of the multiplier
  assign mul_sum = acc_q + (b_q[0] ? a_q : '0);

  // One restoring division step; the remainder stays below the divisor
  assign rem_shift = {acc_q[DATA_W-2:0], a_q[DATA_W-1]};
  assign rem_fits  = (rem_shift >= b_q);
  assign rem_sub   = rem_shift - b_q;

  // Load, step and sign fix of the working registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      if (ctl_i.mode == ALU_DIV) begin
        a_q <= abs_a;
        b_q <= abs_b;
      end else begin
        a_q <= opa_i;
        b_q <= opb_i;
      end
      acc_q   <= '0;
      carry_q <= (ctl_i.mode == ALU_SUB);
      ge_q    <= 1'b1;
      neg_q   <= opa_i[DATA_W-1] ^ opb_i[DATA_W-1];
    end else if (ctl_i.step) begin
      case (ctl_i.mode)
        ALU_ADD, ALU_SUB: begin
          a_q     <= a_q >> 1;
          b_q     <= b_q >> 1;
          acc_q   <= {sum_bit, acc_q[DATA_W-1:1]};
          carry_q <= carry_out;
        end
        ALU_CMP: begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          // Highest differing bit decides; the sign bit counts inverted
          if (a_q[0] != b_q[0]) begin
            ge_q <= ctl_i.last ? b_q[0] : a_q[0];
          end
        end
        ALU_MUL: begin
          acc_q <= mul_sum;
          a_q   <= a_q << 1;
          b_q   <= b_q >> 1;
        end
        ALU_DIV: begin
          acc_q <= rem_fits ? rem_sub : rem_shift;
          a_q   <= {a_q[DATA_W-2:0], rem_fits};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end else if (ctl_i.fix) begin
      acc_q <= neg_q ? (DATA_W'(0) - a_q) : a_q;
    end
  end

  assign result_o = acc_q;
  assign ge_o     = ge_q;

endmodule

// File: hdl/toy_register_machine_execute_core.sv
// Top level of the register machine execute core: sequencer, program counter and register file.
// Sequence: an accepted instruction is loaded; add, sub, mul and bge then run the serial datapath, div
// adds a sign fix, let, print, end and unknown opcodes skip it, and after halt the load is skipped too;
// the datapath takes one bit a cycle. Throughput: one instruction at a time, taken while the previous
// result waits; the next one is not taken until the last has reached the result register.
// Reset: all registers read as zero, program counter 0, halt flag clear, no result pending.
module toy_register_machine_execute_core
  import trm_pkg::*;
#(
  parameter int unsigned NUM_REGS      = 8,
  parameter int unsigned PROGRAM_LINES = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  trm_stream_if.sink   instr_i,
  trm_stream_if.source result_o
);

  localparam int unsigned RW  = $clog2(NUM_REGS);
  localparam int unsigned PCW = $clog2(PROGRAM_LINES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_FIX,
    S_DONE
  } state_e;

  state_e            state_q;
  trm_instr_t        ins_q;
  logic              skip_q;
  logic              ok_a_q;
  logic              ok_b_q;
  logic              dz_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PCW-1:0]    pc_q;
  logic              halt_q;
  logic [NUM_REGS-1:0] reg_valid_q;
  logic              out_valid_q;
  trm_result_t       out_q;

  trm_instr_t        in_pl;
  logic              in_fire;
  logic              done_fire;
  logic [REG_IDX_W-1:0] rd_idx_a;
  logic [REG_IDX_W-1:0] rd_idx_b;
  logic [RW-1:0]     raddr_a;
  logic [RW-1:0]     raddr_b;
  logic              in_range_a;
  logic              in_range_b;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  trm_alu_ctl_t      alu_ctl;
  logic [DATA_W-1:0] alu_res;
  logic              alu_ge;
  logic              uses_alu;
  logic [PCW-1:0]    pc_inc;
  logic [PCW-1:0]    br_tgt;
  logic [PCW-1:0]    pc_d;
  logic              halt_d;
  logic              we;
  logic [RW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  trm_result_t       res_d;

  assign in_pl          = instr_i.payload;
  assign instr_i.ready  = (state_q == S_IDLE);
  assign in_fire        = instr_i.valid && instr_i.ready;
  assign done_fire      = (state_q == S_DONE) && (!out_valid_q || result_o.ready);
  assign result_o.valid = out_valid_q;
  assign result_o.payload = out_q;

  // Pick read ports: bge and print read the first register on port A
  always_comb begin
    rd_idx_a = in_pl.second_reg;
    rd_idx_b = in_pl.third_reg;
    if (in_pl.opcode == OP_BGE) begin
      rd_idx_a = in_pl.first_reg;
      rd_idx_b = in_pl.second_reg;
    end else if (in_pl.opcode == OP_PRINT) begin
      rd_idx_a = in_pl.first_reg;
    end
  end

  assign raddr_a    = RW'(rd_idx_a);
  assign raddr_b    = RW'(rd_idx_b);
  assign in_range_a = (32'(rd_idx_a) < NUM_REGS);
  assign in_range_b = (32'(rd_idx_b) < NUM_REGS);

  // Out-of-range and never-written registers read as zero
  assign opa = ok_a_q ? rdata_a : '0;
  assign opb = ok_b_q ? rdata_b : '0;

  trm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_REGS)
  ) u_regs (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  // Drive the serial datapath
  always_comb begin
    alu_ctl.load = (state_q == S_LOAD);
    alu_ctl.step = (state_q == S_RUN);
    alu_ctl.fix  = (state_q == S_FIX);
    alu_ctl.last = (cnt_q == CNT_W'(DATA_W - 1));
    case (trm_op_e'(ins_q.opcode))
      OP_SUB:  alu_ctl.mode = ALU_SUB;
      OP_MUL:  alu_ctl.mode = ALU_MUL;
      OP_DIV:  alu_ctl.mode = ALU_DIV;
      OP_BGE:  alu_ctl.mode = ALU_CMP;
      default: alu_ctl.mode = ALU_ADD;
    endcase
  end

  assign uses_alu = (ins_q.opcode == OP_ADD) || (ins_q.opcode == OP_SUB) ||
                    (ins_q.opcode == OP_MUL) || (ins_q.opcode == OP_DIV) ||
                    (ins_q.opcode == OP_BGE);

  trm_alu u_alu (
    .clk_i   (clk_i),
    .ctl_i   (alu_ctl),
    .opa_i   (opa),
    .opb_i   (opb),
    .result_o(alu_res),
    .ge_o    (alu_ge)
  );

  // Advance the line, wrapping at the program length
  assign pc_inc = (pc_q == PCW'(PROGRAM_LINES - 1)) ? '0 : pc_q + PCW'(1);

  // Reduce the one-based branch line modulo the program length, one bit a step
  always_comb begin
    logic [PCW:0] rem;
    rem = '0;
    for (int i = BR_W - 1; i >= 0; i--) begin
      rem = {rem[PCW-1:0], ins_q.branch_line[i]};
      if (rem >= (PCW+1)'(PROGRAM_LINES)) begin
        rem = rem - (PCW+1)'(PROGRAM_LINES);
      end
    end
    br_tgt = (rem == '0) ? PCW'(PROGRAM_LINES - 1) : (rem[PCW-1:0] - PCW'(1));
  end

  // Form the write-back and the result of the finished instruction
  always_comb begin
    res_d   = '0;
    pc_d    = pc_inc;
    halt_d  = halt_q;
    we      = 1'b0;
    waddr   = RW'(ins_q.first_reg);
    wdata   = alu_res;
    if (skip_q) begin
      pc_d = pc_q;
    end else begin
      case (trm_op_e'(ins_q.opcode))
        OP_ADD, OP_SUB, OP_MUL: begin
          we = 1'b1;
        end
        OP_DIV: begin
          we = 1'b1;
          if (dz_q) begin
            wdata = '0;
          end
          res_d.divide_by_zero = dz_q;
        end
        OP_LET: begin
          we    = 1'b1;
          wdata = ins_q.immediate_value;
        end
        OP_BGE: begin
          if (alu_ge) begin
            pc_d = br_tgt;
          end
        end
        OP_PRINT: begin
          res_d.print_valid = 1'b1;
          res_d.print_reg   = ins_q.first_reg;
          res_d.print_value = val_q;
        end
        OP_END: begin
          pc_d   = pc_q;
          halt_d = 1'b1;
        end
        default: begin
          res_d.unknown_op = 1'b1;
        end
      endcase
    end
    we              = we && done_fire && (32'(ins_q.first_reg) < NUM_REGS);
    res_d.next_line = LINE_W'(pc_d);
    res_d.halted    = halt_d;
  end

  // Sequencer, architectural state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      reg_valid_q <= '0;
      out_valid_q <= 1'b0;
      skip_q      <= 1'b0;
    end else begin
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ins_q   <= in_pl;
            skip_q  <= halt_q;
            ok_a_q  <= in_range_a && reg_valid_q[raddr_a];
            ok_b_q  <= in_range_b && reg_valid_q[raddr_b];
            state_q <= halt_q ? S_DONE : S_LOAD;
          end
        end
        S_LOAD: begin
          val_q   <= opa;
          dz_q    <= (opb == '0);
          cnt_q   <= '0;
          state_q <= uses_alu ? S_RUN : S_DONE;
        end
        S_RUN: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (alu_ctl.last) begin
            state_q <= (ins_q.opcode == OP_DIV) ? S_FIX : S_DONE;
          end
        end
        S_FIX: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            out_q   <= res_d;
            pc_q    <= pc_d;
            halt_q  <= halt_d;
            if (we) begin
              reg_valid_q[waddr] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
